// ===== rtl/external_interrupt_edge_controller_core_assert.svh =====
// Assertion macros for the external interrupt edge controller.
// Used by external_interrupt_edge_controller_core; needs no other file.
`ifndef EXTERNAL_INTERRUPT_EDGE_CONTROLLER_CORE_ASSERT_SVH
`define EXTERNAL_INTERRUPT_EDGE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define EIEC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eiec assertion failed");

// Next-cycle implication, checked out of reset.
`define EIEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eiec assertion failed");

`endif

// ===== rtl/eiec_pkg.sv =====
// Shared types and constants for the external interrupt edge controller.
// No dependencies; imported by external_interrupt_edge_controller_core.
package eiec_pkg;

  // Number of implemented interrupt lines (4..16) and pin ports (1..4).
  localparam int LINE_COUNT = 16;
  localparam int PORT_COUNT = 4;

  // Fixed geometry of the register file and pin bus.
  localparam int REG_WIDTH  = 16;
  localparam int PORT_WIDTH = 16;
  localparam int SEL_WIDTH  = 4;
  localparam int SEL_WORDS  = 4;
  localparam int MAX_PORTS  = 4;

  // Lines that exist; bits above them are held at zero.
  localparam logic [REG_WIDTH-1:0] LINE_VALID = (LINE_COUNT >= REG_WIDTH) ?
      {REG_WIDTH{1'b1}} : REG_WIDTH'((32'd1 << LINE_COUNT) - 32'd1);

  // Line groups behind the three interrupt outputs.
  localparam logic [REG_WIDTH-1:0] GROUP0_LINES = 16'h0003;
  localparam logic [REG_WIDTH-1:0] GROUP1_LINES = 16'h000C;
  localparam logic [REG_WIDTH-1:0] GROUP2_LINES = 16'hFFF0;

  // Commands carried by an input word.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  // Register addresses.
  localparam logic [2:0] ADDR_SEL0    = 3'd0;
  localparam logic [2:0] ADDR_SEL3    = 3'd3;
  localparam logic [2:0] ADDR_MASK    = 3'd4;
  localparam logic [2:0] ADDR_RISING  = 3'd5;
  localparam logic [2:0] ADDR_FALLING = 3'd6;
  localparam logic [2:0] ADDR_PENDING = 3'd7;

endpackage

// ===== rtl/external_interrupt_edge_controller_core.sv =====
// External interrupt edge controller, sixteen lines, registered single pass.
// Depends on eiec_pkg and external_interrupt_edge_controller_core_assert.svh.
//
// Usage: every input word is a pin sample tick, a register read or a register
// write. A word is accepted on a clock edge with in_valid high and in_stall low.
// It is held in an input register; when it moves on it is processed against
// the controller state and its result word lands in the output register,
// which raises out_valid. One word in, one word out. The result word is
// taken on a clock edge with out_valid high and out_stall low.
// Throughput is one word per cycle: the input register hands its word on to the
// output register whenever the output register is empty or being taken in the
// same cycle. When the receiver raises out_stall the result word holds, the
// input register fills, and in_stall rises until the output word is taken.
// A tick routes, per line, the pin of the selected port, sets pending on an
// enabled edge and keeps the levels for the next tick. Pending is set whatever
// the mask; out_irq_groups reports pending AND mask in three groups.
// Synchronous reset clears the state registers, previous levels and both valids.
`include "external_interrupt_edge_controller_core_assert.svh"

module external_interrupt_edge_controller_core
  import eiec_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_command,
  input  logic [2:0]              in_reg_address,
  input  logic [REG_WIDTH-1:0]    in_write_data,
  input  logic [63:0]             in_pin_levels,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [REG_WIDTH-1:0]    out_read_data,
  output logic [2:0]              out_irq_groups,
  output logic [REG_WIDTH-1:0]    out_pending_lines
);

  // Input register.
  logic                 s1_valid_r;
  logic [1:0]           s1_cmd_r;
  logic [2:0]           s1_addr_r;
  logic [REG_WIDTH-1:0] s1_wdata_r;
  logic [63:0]          s1_pins_r;

  // Controller state.
  logic [REG_WIDTH-1:0] port_sel_r [SEL_WORDS];
  logic [REG_WIDTH-1:0] port_sel_nxt [SEL_WORDS];
  logic [REG_WIDTH-1:0] mask_r, mask_nxt;
  logic [REG_WIDTH-1:0] rising_r, rising_nxt;
  logic [REG_WIDTH-1:0] falling_r, falling_nxt;
  logic [REG_WIDTH-1:0] pending_r, pending_nxt;
  logic [REG_WIDTH-1:0] prev_lvl_r, prev_lvl_nxt;

  // Output register.
  logic                 out_valid_r;
  logic [REG_WIDTH-1:0] out_rdata_r, out_rdata_nxt;
  logic [2:0]           out_irq_r, out_irq_nxt;
  logic [REG_WIDTH-1:0] out_pend_r;

  logic                 advance;
  logic                 in_take;
  logic [REG_WIDTH-1:0] levels;
  logic [REG_WIDTH-1:0] active;
  cmd_t                 s1_cmd;

  assign s1_cmd   = cmd_t'(s1_cmd_r);
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  function automatic logic in_range_pin(input logic [63:0] pins, input int p, input int l);
    return pins[6'(p * PORT_WIDTH + l)];
  endfunction

  // Route the selected port pin onto each line.
  always_comb begin
    logic [SEL_WIDTH-1:0] sel;
    levels = '0;
    for (int l = 0; l < REG_WIDTH; l++) begin
      sel = port_sel_r[2'(l >> 2)][(l % 4) * SEL_WIDTH +: SEL_WIDTH];
      for (int p = 0; p < MAX_PORTS; p++) begin
        if (p < PORT_COUNT && sel == SEL_WIDTH'(p)) begin
          levels[l] = in_range_pin(s1_pins_r, p, l);
        end
      end
    end
    levels = levels & LINE_VALID;
  end

  // State update and result for the word in the input register.
  always_comb begin
    port_sel_nxt  = port_sel_r;
    mask_nxt      = mask_r;
    rising_nxt    = rising_r;
    falling_nxt   = falling_r;
    pending_nxt   = pending_r;
    prev_lvl_nxt  = prev_lvl_r;
    out_rdata_nxt = '0;
    case (s1_cmd)
      CMD_TICK: begin
        pending_nxt  = (pending_r | (levels & ~prev_lvl_r & rising_r)
                       | (~levels & prev_lvl_r & falling_r)) & LINE_VALID;
        prev_lvl_nxt = levels;
      end
      CMD_READ: begin
        case (s1_addr_r)
          ADDR_MASK:    out_rdata_nxt = mask_r;
          ADDR_RISING:  out_rdata_nxt = rising_r;
          ADDR_FALLING: out_rdata_nxt = falling_r;
          ADDR_PENDING: out_rdata_nxt = pending_r;
          default:      out_rdata_nxt = port_sel_r[s1_addr_r[1:0]];
        endcase
      end
      CMD_WRITE: begin
        case (s1_addr_r)
          ADDR_MASK:    mask_nxt    = s1_wdata_r & LINE_VALID;
          ADDR_RISING:  rising_nxt  = s1_wdata_r & LINE_VALID;
          ADDR_FALLING: falling_nxt = s1_wdata_r & LINE_VALID;
          ADDR_PENDING: pending_nxt = pending_r & ~s1_wdata_r;
          default:      port_sel_nxt[s1_addr_r[1:0]] = s1_wdata_r;
        endcase
      end
      default: begin
      end
    endcase
    active = pending_nxt & mask_nxt;
    out_irq_nxt = {|(active & GROUP2_LINES), |(active & GROUP1_LINES),
                   |(active & GROUP0_LINES)};
  end

  // Input register: load when empty or when its word moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
    if (in_take) begin
      s1_cmd_r   <= in_command;
      s1_addr_r  <= in_reg_address;
      s1_wdata_r <= in_write_data;
      s1_pins_r  <= in_pin_levels;
    end
  end

  // Controller state commits when a word is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SEL_WORDS; i++) begin
        port_sel_r[i] <= '0;
      end
      mask_r     <= '0;
      rising_r   <= '0;
      falling_r  <= '0;
      pending_r  <= '0;
      prev_lvl_r <= '0;
    end else if (advance) begin
      port_sel_r <= port_sel_nxt;
      mask_r     <= mask_nxt;
      rising_r   <= rising_nxt;
      falling_r  <= falling_nxt;
      pending_r  <= pending_nxt;
      prev_lvl_r <= prev_lvl_nxt;
    end
  end

  // Output register: holds its word while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_rdata_r <= out_rdata_nxt;
      out_irq_r   <= out_irq_nxt;
      out_pend_r  <= pending_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rdata_r;
  assign out_irq_groups    = out_irq_r;
  assign out_pending_lines = out_pend_r;

  // Pending never holds a bit for a line that does not exist.
  `EIEC_ASSERT_NOW(a_pend_in_range, clk, rst_n, 1'b1, (pending_r & ~LINE_VALID) == '0)
  // Only ticks move the sampled levels.
  `EIEC_ASSERT_NEXT(a_prev_hold, clk, rst_n, advance && s1_cmd != CMD_TICK, $stable(prev_lvl_r))
  // A pending write only clears bits.
  `EIEC_ASSERT_NEXT(a_pend_w1c, clk, rst_n,
    advance && s1_cmd == CMD_WRITE && s1_addr_r == ADDR_PENDING,
    (pending_r & ~$past(pending_r)) == '0)
  // Words other than reads return zero data.
  `EIEC_ASSERT_NEXT(a_rdata_zero, clk, rst_n, advance && s1_cmd != CMD_READ, out_rdata_r == '0)
  // A held input word is never dropped.
  `EIEC_ASSERT_NEXT(a_s1_keep, clk, rst_n, s1_valid_r && !advance, s1_valid_r)

endmodule
